### rtl/core/icv_pkg.sv
// shared types and constants for the integer 2-d valid convolution
`timescale 1ns / 1ps

package icv_pkg;

    localparam int KERNEL_MAX = 3;
    localparam int PIX_W      = 16;
    localparam int CFG_DATA_W = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int DIM_CFG_W  = 11;
    localparam int KER_CFG_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_ROW0     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_ROW1     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_ROW2     = 3'd6;

    typedef logic [PIX_W-1:0] pix_t;

    // [row][col], row 0 is the oldest line, col KERNEL_MAX-1 the newest pixel
    typedef pix_t [KERNEL_MAX-1:0][KERNEL_MAX-1:0] win_t;

    typedef struct packed {
        logic last;
    } tag_t;

endpackage

### rtl/core/icv_mac.sv
// multiply stage and sum stage with the result output register
`timescale 1ns / 1ps

module icv_mac (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  icv_pkg::tag_t            in_tag,
    input  icv_pkg::win_t            in_win,
    input  icv_pkg::win_t            in_coef,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [icv_pkg::PIX_W-1:0] m_tdata,   // [15:0] result_value
    output logic                     m_tlast     // frame_last
);

    logic           prod_valid_reg;
    icv_pkg::tag_t  prod_tag_reg;
    icv_pkg::win_t  prod_reg;
    icv_pkg::win_t  prod_next;
    icv_pkg::pix_t  sum_next;
    logic           out_ready;
    logic           prod_fire;

    assign out_ready = !m_tvalid || m_tready;
    assign prod_fire = prod_valid_reg && out_ready;
    assign in_ready  = !prod_valid_reg || prod_fire;

    always_comb begin
        for (int i = 0; i < icv_pkg::KERNEL_MAX; i++) begin
            for (int j = 0; j < icv_pkg::KERNEL_MAX; j++) begin
                prod_next[i][j] = icv_pkg::PIX_W'($signed(in_coef[i][j]) *
                                                  $signed(in_win[i][j]));
            end
        end
    end

    // sum kept modulo 2^16
    always_comb begin
        sum_next = '0;
        for (int i = 0; i < icv_pkg::KERNEL_MAX; i++) begin
            for (int j = 0; j < icv_pkg::KERNEL_MAX; j++) begin
                sum_next = sum_next + prod_reg[i][j];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
            m_tvalid       <= 1'b0;
        end else begin
            if (in_ready) begin
                prod_valid_reg <= in_valid;
            end
            if (out_ready) begin
                m_tvalid <= prod_valid_reg;
            end
        end
        if (in_ready && in_valid) begin
            prod_reg     <= prod_next;
            prod_tag_reg <= in_tag;
        end
        if (prod_fire) begin
            m_tdata <= sum_next;
            m_tlast <= prod_tag_reg.last;
        end
    end

endmodule

### rtl/core/int_conv2d_valid_top.sv
// top level: config registers, position counters, line memory and window
`timescale 1ns / 1ps

//  channel   ports                        beat
//  -------   --------------------------   ---------------------------------
//  input     s_tvalid s_tready s_tdata    pixel_value
//  result    m_tvalid m_tready m_tdata    result_value, frame_last on tlast
//  config    cfg_wen cfg_index cfg_wdata  one register write per cycle
//
//  one pixel per cycle while no result stalls; results pass stage one, the product and the output register
//  the pace is set by the line memory: one read and one write per cycle
//  reset clears counters, window and valid flags; no memory clearing pass
//  a stalled result holds the pipeline stages behind it and then s_tready

module int_conv2d_valid_top #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [icv_pkg::PIX_W-1:0]     s_tdata,    // [15:0] pixel_value
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [icv_pkg::PIX_W-1:0]     m_tdata,    // [15:0] result_value
    output logic                          m_tlast,
    input  logic                          cfg_wen,
    input  logic [icv_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [icv_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int KM    = icv_pkg::KERNEL_MAX;
    localparam int PW    = icv_pkg::PIX_W;
    localparam int MEM_W = (KM - 1) * PW;

    typedef icv_pkg::pix_t [KM-1:0] coef_row_t;

    // configuration
    logic [icv_pkg::DIM_CFG_W-1:0] width_cfg_reg;
    logic [icv_pkg::DIM_CFG_W-1:0] height_cfg_reg;
    logic [icv_pkg::KER_CFG_W-1:0] kw_cfg_reg;
    logic [icv_pkg::KER_CFG_W-1:0] kh_cfg_reg;
    coef_row_t                     coef_row_reg [KM];

    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;
    logic [icv_pkg::KER_CFG_W-1:0] kw_eff;
    logic [icv_pkg::KER_CFG_W-1:0] kh_eff;
    icv_pkg::win_t coef_eff;
    icv_pkg::win_t win_eff;

    // position counters
    logic [AW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic          col_wrap;
    logic          row_wrap;
    logic          produce;
    logic          frame_end;

    // line memory: [PW-1:0] line r-1, upper half line r-2
    logic [MEM_W-1:0] line_mem [MAX_WIDTH];
    logic [MEM_W-1:0] rd_data_reg;
    logic [MEM_W-1:0] fwd_data_reg;
    logic             fwd_sel_reg;
    logic [MEM_W-1:0] rd_eff;
    logic [MEM_W-1:0] wr_data;

    // stage one
    logic          s1_valid_reg;
    icv_pkg::pix_t s1_pix_reg;
    logic [AW-1:0] s1_addr_reg;
    logic          s1_prod_reg;
    icv_pkg::tag_t s1_tag_reg;
    logic          s1_fire;
    logic          accept;

    icv_pkg::win_t window_reg;
    icv_pkg::win_t window_next;
    icv_pkg::pix_t [KM-1:0] column;

    logic          mac_ready;

    // effective sizes
    always_comb begin
        if (width_cfg_reg == '0) begin
            w_eff = WW'(1);
        end else if (32'(width_cfg_reg) > 32'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(width_cfg_reg);
        end
        if (height_cfg_reg == '0) begin
            h_eff = HW'(1);
        end else if (32'(height_cfg_reg) > 32'(MAX_HEIGHT)) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = HW'(height_cfg_reg);
        end
        kw_eff = (kw_cfg_reg == '0) ? 2'd1 : kw_cfg_reg;
        kh_eff = (kh_cfg_reg == '0) ? 2'd1 : kh_cfg_reg;
    end

    // kernel aligned to the bottom-right corner of the window
    always_comb begin
        int ky;
        int kx;
        for (int i = 0; i < KM; i++) begin
            for (int j = 0; j < KM; j++) begin
                ky = i + int'(kh_eff) - KM;
                kx = j + int'(kw_eff) - KM;
                if (ky >= 0 && kx >= 0) begin
                    coef_eff[i][j] = coef_row_reg[2'(ky)][2'(kx)];
                    win_eff[i][j]  = window_next[i][j];
                end else begin
                    coef_eff[i][j] = '0;
                    win_eff[i][j]  = '0;
                end
            end
        end
    end

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = !s1_valid_reg || s1_fire;
    assign s1_fire   = s1_valid_reg && (!s1_prod_reg || mac_ready);

    assign col_wrap  = (WW'(col_reg) == w_eff - WW'(1));
    assign row_wrap  = (HW'(row_reg) == h_eff - HW'(1));
    assign frame_end = col_wrap && row_wrap;
    assign produce   = (w_eff >= WW'(kw_eff)) && (h_eff >= HW'(kh_eff)) &&
                       (col_reg >= AW'(kw_eff - 2'd1)) &&
                       (row_reg >= RW'(kh_eff - 2'd1));

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_wen && (cfg_index <= icv_pkg::REG_COEF_ROW2)) begin
            // any listed register restarts the frame
            col_next = '0;
            row_next = '0;
        end else if (accept) begin
            if (col_wrap) begin
                col_next = '0;
                row_next = row_wrap ? '0 : row_reg + RW'(1);
            end else begin
                col_next = col_reg + AW'(1);
            end
        end
    end

    // new column: oldest line first, current pixel last
    assign rd_eff  = fwd_sel_reg ? fwd_data_reg : rd_data_reg;
    assign wr_data = {rd_eff[PW-1:0], s1_pix_reg};

    always_comb begin
        for (int i = 0; i < KM - 1; i++) begin
            column[i] = rd_eff[(KM - 2 - i) * PW +: PW];
        end
        column[KM-1] = s1_pix_reg;
        for (int i = 0; i < KM; i++) begin
            for (int j = 0; j < KM - 1; j++) begin
                window_next[i][j] = window_reg[i][j+1];
            end
            window_next[i][KM-1] = column[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_cfg_reg  <= icv_pkg::DIM_CFG_W'(1024);
            height_cfg_reg <= icv_pkg::DIM_CFG_W'(1024);
            kw_cfg_reg     <= 2'd3;
            kh_cfg_reg     <= 2'd3;
            for (int k = 0; k < KM; k++) begin
                coef_row_reg[k] <= '0;
            end
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            fwd_sel_reg  <= 1'b0;
            window_reg   <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (cfg_wen) begin
                case (cfg_index)
                    icv_pkg::REG_IMAGE_WIDTH: begin
                        width_cfg_reg <= cfg_wdata[icv_pkg::DIM_CFG_W-1:0];
                    end
                    icv_pkg::REG_IMAGE_HEIGHT: begin
                        height_cfg_reg <= cfg_wdata[icv_pkg::DIM_CFG_W-1:0];
                    end
                    icv_pkg::REG_KERNEL_WIDTH: begin
                        kw_cfg_reg <= cfg_wdata[icv_pkg::KER_CFG_W-1:0];
                    end
                    icv_pkg::REG_KERNEL_HEIGHT: begin
                        kh_cfg_reg <= cfg_wdata[icv_pkg::KER_CFG_W-1:0];
                    end
                    icv_pkg::REG_COEF_ROW0: begin
                        coef_row_reg[0] <= cfg_wdata;
                    end
                    icv_pkg::REG_COEF_ROW1: begin
                        coef_row_reg[1] <= cfg_wdata;
                    end
                    icv_pkg::REG_COEF_ROW2: begin
                        coef_row_reg[2] <= cfg_wdata;
                    end
                    default: begin
                    end
                endcase
            end
            if (s_tready) begin
                s1_valid_reg <= s_tvalid;
            end
            if (accept) begin
                fwd_sel_reg <= s1_fire && (s1_addr_reg == col_reg);
            end
            if (s1_fire) begin
                window_reg <= window_next;
            end
        end
    end

    // stage one payload and forwarding data
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_pix_reg      <= s_tdata;
            s1_addr_reg     <= col_reg;
            s1_prod_reg     <= produce;
            s1_tag_reg.last <= frame_end;
            fwd_data_reg    <= wr_data;
        end
    end

    // line memory, read on accept, written back as stage one retires
    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_data_reg <= line_mem[col_reg];
        end
        if (s1_fire) begin
            line_mem[s1_addr_reg] <= wr_data;
        end
    end

    icv_mac u_mac (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s1_valid_reg && s1_prod_reg),
        .in_ready (mac_ready),
        .in_tag   (s1_tag_reg),
        .in_win   (win_eff),
        .in_coef  (coef_eff),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

### test/conv2d_checker.sv
// checker for the 2-d convolution: tracks register writes and pixel beats, predicts and compares sums
`timescale 1ns / 1ps

module conv2d_checker #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [icv_pkg::PIX_W-1:0]       s_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [icv_pkg::PIX_W-1:0]       m_tdata,
    input  logic                            m_tlast,
    input  logic                            cfg_wen,
    input  logic [icv_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [icv_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output int                              error_count,
    output int                              sums_waiting,
    output int                              sum_count,
    output int                              frame_count
);

    localparam int KM = icv_pkg::KERNEL_MAX;

    typedef struct packed {
        icv_pkg::pix_t value;
        logic          last;
    } window_sum_t;

    window_sum_t expected_sums[$];

    logic [icv_pkg::DIM_CFG_W-1:0]  width_reg;
    logic [icv_pkg::DIM_CFG_W-1:0]  height_reg;
    logic [icv_pkg::KER_CFG_W-1:0]  kcols_reg;
    logic [icv_pkg::KER_CFG_W-1:0]  krows_reg;
    logic [icv_pkg::CFG_DATA_W-1:0] coef_reg [KM];

    icv_pkg::pix_t line_mem [KM-1][MAX_WIDTH];
    icv_pkg::win_t window;
    int            col_pos;
    int            row_pos;

    function automatic int clamp_size(int v, int hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // slide the window by one pixel and queue the sum if the kernel fits
    task automatic convolve_pixel(input icv_pkg::pix_t px);
        int                      w, h, kw, kh, c, r;
        icv_pkg::pix_t           fresh [KM];
        logic [icv_pkg::PIX_W-1:0] acc;
        logic signed [31:0]      prod;
        window_sum_t             sum;
        w  = clamp_size(int'(width_reg), MAX_WIDTH);
        h  = clamp_size(int'(height_reg), MAX_HEIGHT);
        kw = clamp_size(int'(kcols_reg), KM);
        kh = clamp_size(int'(krows_reg), KM);
        c  = (col_pos >= w) ? 0 : col_pos;
        r  = (row_pos >= h) ? 0 : row_pos;

        // oldest line first, current pixel last
        for (int i = 0; i < KM - 1; i++) fresh[i] = line_mem[KM-2-i][c];
        fresh[KM-1] = px;
        for (int i = 0; i < KM; i++) begin
            for (int j = 0; j < KM - 1; j++) window[i][j] = window[i][j+1];
            window[i][KM-1] = fresh[i];
        end
        for (int i = KM - 1; i > 1; i--) line_mem[i-1][c] = line_mem[i-2][c];
        line_mem[0][c] = px;

        if (w >= kw && h >= kh && c + 1 >= kw && r + 1 >= kh) begin
            acc = '0;
            for (int ky = 0; ky < kh; ky++) begin
                for (int kx = 0; kx < kw; kx++) begin
                    prod = $signed(coef_reg[ky][16*kx +: 16]) *
                           $signed(window[KM-kh+ky][KM-kw+kx]);
                    acc  = acc + prod[icv_pkg::PIX_W-1:0];
                end
            end
            sum.value = acc;
            sum.last  = (r == h - 1) && (c == w - 1);
            expected_sums.push_back(sum);
        end

        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        col_pos = c;
        row_pos = r;
    endtask

    always @(posedge aclk) begin
        window_sum_t want;
        if (!aresetn) begin
            width_reg  = 11'd1024;
            height_reg = 11'd1024;
            kcols_reg  = 2'd3;
            krows_reg  = 2'd3;
            foreach (coef_reg[i]) coef_reg[i] = '0;
            foreach (line_mem[i, j]) line_mem[i][j] = '0;
            window  = '0;
            col_pos = 0;
            row_pos = 0;
            expected_sums.delete();
            error_count = 0;
            sum_count   = 0;
            frame_count = 0;
        end else begin
            if (cfg_wen) begin
                case (cfg_index)
                    icv_pkg::REG_IMAGE_WIDTH:   width_reg   = cfg_wdata[icv_pkg::DIM_CFG_W-1:0];
                    icv_pkg::REG_IMAGE_HEIGHT:  height_reg  = cfg_wdata[icv_pkg::DIM_CFG_W-1:0];
                    icv_pkg::REG_KERNEL_WIDTH:  kcols_reg   = cfg_wdata[icv_pkg::KER_CFG_W-1:0];
                    icv_pkg::REG_KERNEL_HEIGHT: krows_reg   = cfg_wdata[icv_pkg::KER_CFG_W-1:0];
                    icv_pkg::REG_COEF_ROW0:     coef_reg[0] = cfg_wdata;
                    icv_pkg::REG_COEF_ROW1:     coef_reg[1] = cfg_wdata;
                    icv_pkg::REG_COEF_ROW2:     coef_reg[2] = cfg_wdata;
                    default: ;
                endcase
                if (cfg_index <= icv_pkg::REG_COEF_ROW2) begin
                    col_pos = 0;
                    row_pos = 0;
                end
            end

            if (s_tvalid && s_tready) convolve_pixel(s_tdata);

            if (m_tvalid && m_tready) begin
                sum_count++;
                if (m_tlast === 1'b1) frame_count++;
                if (expected_sums.size() == 0) begin
                    $error("result beat with no sum expected: result_value %0d, frame_last %0b",
                           $signed(m_tdata), m_tlast);
                    error_count++;
                end else begin
                    want = expected_sums.pop_front();
                    if (m_tdata !== want.value) begin
                        $error("result_value: expected %0d, got %0d",
                               $signed(want.value), $signed(m_tdata));
                        error_count++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("frame_last: expected %0b, got %0b", want.last, m_tlast);
                        error_count++;
                    end
                end
            end
        end
        sums_waiting = expected_sums.size();
    end

endmodule

### test/testbench.sv
// testbench top: clock, reset, register settings, pixel stimulus and verdict for the convolution
`timescale 1ns / 1ps

module testbench;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_PIXELS  = 240;
    localparam int SETTLE_CYCLES  = 8;
    localparam int LONG_HOLD      = 300;

    logic                             aclk;
    logic                             aresetn;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [icv_pkg::PIX_W-1:0]        s_tdata;
    logic                             m_tvalid;
    logic                             m_tready;
    logic [icv_pkg::PIX_W-1:0]        m_tdata;
    logic                             m_tlast;
    logic                             cfg_wen;
    logic [icv_pkg::CFG_IDX_W-1:0]    cfg_index;
    logic [icv_pkg::CFG_DATA_W-1:0]   cfg_wdata;

    int error_count, sums_waiting, sum_count, frame_count;
    int pixels_sent    = 0;
    int configs_loaded = 0;
    int stall_cycles   = 0;
    bit steady;
    bit hold_request;

    int_conv2d_valid_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    conv2d_checker scoreboard (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .cfg_wen      (cfg_wen),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .error_count  (error_count),
        .sums_waiting (sums_waiting),
        .sum_count    (sum_count),
        .frame_count  (frame_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wen) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $error("no beat for %0d cycles, %0d sums still expected", stall_cycles, sums_waiting);
            $display("*** FAILED ***");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [47:0] pick_coefs();
        return {pick_word(), pick_word(), pick_word()};
    endfunction

    task automatic send_pixel(input logic [15:0] px);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        pixels_sent++;
    endtask

    task automatic send_pixels(input int count);
        repeat (count) send_pixel(pick_word());
    endtask

    // wait until every sum is back and the pipeline has emptied
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sums_waiting != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic put_reg(input logic [2:0] idx, input logic [47:0] val);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
    endtask

    task automatic load_config(input logic [10:0] w, input logic [10:0] h,
                               input logic [1:0] kw, input logic [1:0] kh,
                               input logic [47:0] r0, input logic [47:0] r1,
                               input logic [47:0] r2);
        settle();
        put_reg(icv_pkg::REG_IMAGE_WIDTH, 48'(w));
        put_reg(icv_pkg::REG_IMAGE_HEIGHT, 48'(h));
        put_reg(icv_pkg::REG_KERNEL_WIDTH, 48'(kw));
        put_reg(icv_pkg::REG_KERNEL_HEIGHT, 48'(kh));
        put_reg(icv_pkg::REG_COEF_ROW0, r0);
        put_reg(icv_pkg::REG_COEF_ROW1, r1);
        put_reg(icv_pkg::REG_COEF_ROW2, r2);
        cfg_wen <= 1'b0;
        configs_loaded++;
    endtask

    // result side: random pauses, plus one long hold when asked
    initial begin
        int gap;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            gap = steady ? 0 : $urandom_range(0, 3);
            if (hold_request) begin
                hold_request = 1'b0;
                gap = LONG_HOLD;
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    initial begin
        int          goal, fw, fh, frame_px;
        logic [10:0] w, h;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        cfg_wen      = 1'b0;
        cfg_index    = '0;
        cfg_wdata    = '0;
        steady       = 1'b0;
        hold_request = 1'b0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // full 3x3 kernel on one 3x3 image, extreme coefficients and pixels
        load_config(11'd3, 11'd3, 2'd3, 2'd3, {16'h0001, 16'h8000, 16'h7FFF},
                    {16'h8000, 16'h7FFF, 16'hFFFF}, {16'h7FFF, 16'h8000, 16'h0000});
        for (int i = 0; i < 9; i++) send_pixel((i == 4) ? 16'hFFFF : (i[0] ? 16'h7FFF : 16'h8000));

        // image smaller than kernel, then zero sizes
        load_config(11'd2, 11'd2, 2'd3, 2'd3, pick_coefs(), pick_coefs(), pick_coefs());
        send_pixels(4);
        load_config(11'd0, 11'd0, 2'd0, 2'd0, pick_coefs(), pick_coefs(), pick_coefs());
        send_pixels(3);

        // restart in the middle of a frame
        load_config(11'd3, 11'd2, 2'd2, 2'd2, pick_coefs(), pick_coefs(), pick_coefs());
        send_pixels(4);
        load_config(11'd3, 11'd2, 2'd2, 2'd2, pick_coefs(), pick_coefs(), pick_coefs());
        send_pixels(6);

        // saturated width over full line memory depth, with a long result stall
        load_config(11'h7FF, 11'd1, 2'd3, 2'd1, pick_coefs(), pick_coefs(), pick_coefs());
        hold_request = 1'b1;
        send_pixels(1032);

        // saturated height on a one-pixel-wide image
        load_config(11'd1, 11'h7FF, 2'd1, 2'd3, pick_coefs(), pick_coefs(), pick_coefs());
        send_pixels(16);

        goal = pixels_sent + RANDOM_PIXELS;
        while (pixels_sent < goal) begin
            case ($urandom_range(0, 9))
                0: w = 11'd0;
                1: w = 11'($urandom_range(13, 40));
                default: w = 11'($urandom_range(1, 12));
            endcase
            h = ($urandom_range(0, 9) == 0) ? 11'd0 : 11'($urandom_range(1, 8));
            load_config(w, h, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                        pick_coefs(), pick_coefs(), pick_coefs());
            steady   = ($urandom_range(0, 3) == 0);
            fw       = (w == 0) ? 1 : int'(w);
            fh       = (h == 0) ? 1 : int'(h);
            frame_px = fw * fh;
            repeat ($urandom_range(1, 3)) send_pixels(frame_px);
            if (frame_px > 1 && $urandom_range(0, 5) == 0)
                send_pixels($urandom_range(1, frame_px - 1));
        end
        steady = 1'b0;
        settle();

        $display("run summary: %0d pixel beats under %0d register settings",
                 pixels_sent, configs_loaded);
        $display("%0d sums checked, %0d frame ends; zero, small and saturated sizes",
                 sum_count, frame_count);
        $display("covered kernels 0..3, restarts and a long stall");
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
